// ===== hdl/ldpp_pkg.sv =====
// ldpp_pkg: shared types, constants and helpers for the lens distortion point pair core.
// No dependencies; every other file in hdl/ except ldpp_delay imports it.
`default_nettype none

package ldpp_pkg;

	// Coordinate / coefficient word width (signed, fixed by the port payload)
	localparam int COORD_WIDTH = 32;
	// Default number of fraction bits
	localparam int FRAC_BITS_DFLT = 24;
	// Digit width of the multiplier partial products: (DIGIT+1) x (DIGIT+1) signed
	localparam int MUL_DIGIT = 31;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_K1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_K2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_K3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_P1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_P2 = 3'd4;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] source_x;
		logic signed [COORD_WIDTH-1:0] source_y;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
	} ldpp_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] source_x_out;
		logic signed [COORD_WIDTH-1:0] source_y_out;
		logic signed [COORD_WIDTH-1:0] target_x_out;
		logic signed [COORD_WIDTH-1:0] target_y_out;
		logic                          saturated;
	} ldpp_out_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] k1;
		logic signed [COORD_WIDTH-1:0] k2;
		logic signed [COORD_WIDTH-1:0] k3;
		logic signed [COORD_WIDTH-1:0] p1;
		logic signed [COORD_WIDTH-1:0] p2;
	} ldpp_coef_t;

	// One corrected point from a lane
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic                          sat;
	} ldpp_lane_t;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Register levels between operands and product in ldpp_mul: one partial product
	// register plus one register per adder tree level.
	function automatic int mul_lat(input int wa, input int wb);
		int na;
		int nb;
		na = (wa + MUL_DIGIT - 1) / MUL_DIGIT;
		nb = (wb + MUL_DIGIT - 1) / MUL_DIGIT;
		return 1 + $clog2(na * nb);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lens_distortion_point_pair_core.sv =====
// lens_distortion_point_pair_core: radial-tangential lens distortion of a
// source/destination point pair. Uses ldpp_pkg, ldpp_lane, ldpp_merge.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | start (busy always low)   | pair   : ldpp_in_t  (4 x Q8.24)
//  result   | done, one-cycle strobe    | result : ldpp_out_t (4 x Q8.24, sat)
//  config   | cfg_we                    | cfg_index, cfg_data (k1 k2 k3 p1 p2)
//
// One pair per cycle is taken; two identical lanes run the source and the
// destination point side by side. Start reaches done through the lane
// pipeline plus one merge register; the lane path is the squares multiply,
// the chain of three multiplier trees of the radial polynomial and the final
// coordinate multiply. Reset clears the coefficients to zero and empties the
// pipeline; no clearing pass. Results cannot be held off, so nothing stalls.
`default_nettype none

module lens_distortion_point_pair_core
	import ldpp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ldpp_in_t               pair,
	output logic                   done,
	output ldpp_out_t              result,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	ldpp_coef_t coef_q;
	ldpp_lane_t src_res, dst_res;
	logic       src_valid, dst_valid;

	// fully pipelined: a transfer can be taken every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_K1:  coef_q.k1 <= cfg_data;
				CFG_K2:  coef_q.k2 <= cfg_data;
				CFG_K3:  coef_q.k3 <= cfg_data;
				CFG_P1:  coef_q.p1 <= cfg_data;
				CFG_P2:  coef_q.p2 <= cfg_data;
				default: ;
			endcase
		end
	end

	ldpp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_src (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.u         (pair.source_x),
		.v         (pair.source_y),
		.coef      (coef_q),
		.res_valid (src_valid),
		.res       (src_res)
	);

	ldpp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_dst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.u         (pair.target_x),
		.v         (pair.target_y),
		.coef      (coef_q),
		.res_valid (dst_valid),
		.res       (dst_res)
	);

	ldpp_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src       (src_res),
		.dst_valid (dst_valid),
		.dst       (dst_res),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hdl/ldpp_mul.sv =====
// ldpp_mul: pipelined signed multiplier of arbitrary width, split into
// 32x32 signed partial products summed by a registered adder tree. Uses ldpp_pkg.
`default_nettype none

module ldpp_mul
	import ldpp_pkg::*;
#(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                    clk,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int WP     = WA + WB;
	localparam int NA     = (WA + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NB     = (WB + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int AXW    = NA * MUL_DIGIT;
	localparam int BXW    = NB * MUL_DIGIT;
	localparam int NPP    = NA * NB;
	localparam int LEVELS = mul_lat(WA, WB) - 1;
	localparam int NLEAF  = 1 << LEVELS;
	localparam int PW     = imax(WP, 2 * MUL_DIGIT + 2);

	logic signed [AXW-1:0] a_ext;
	logic signed [BXW-1:0] b_ext;

	// Heap ordered tree: node n sums nodes 2n+1 and 2n+2, leaves start at NLEAF-1.
	// Sums wrap modulo 2^WP; the final product always fits.
	logic [WP-1:0] node_q [2*NLEAF-1];

	assign a_ext = AXW'(a);
	assign b_ext = BXW'(b);

	for (genvar i = 0; i < NA; i++) begin : g_a
		for (genvar j = 0; j < NB; j++) begin : g_b
			logic signed [MUL_DIGIT:0]     da;
			logic signed [MUL_DIGIT:0]     db;
			logic signed [2*MUL_DIGIT+1:0] prod;
			logic signed [PW-1:0]          prod_ext;

			// top digit carries the sign, lower digits are unsigned
			if (i == NA - 1) begin : g_atop
				assign da = {a_ext[AXW-1], a_ext[i*MUL_DIGIT +: MUL_DIGIT]};
			end else begin : g_alow
				assign da = {1'b0, a_ext[i*MUL_DIGIT +: MUL_DIGIT]};
			end
			if (j == NB - 1) begin : g_btop
				assign db = {b_ext[BXW-1], b_ext[j*MUL_DIGIT +: MUL_DIGIT]};
			end else begin : g_blow
				assign db = {1'b0, b_ext[j*MUL_DIGIT +: MUL_DIGIT]};
			end

			assign prod     = da * db;
			assign prod_ext = PW'(prod);

			always_ff @(posedge clk) begin
				node_q[NLEAF-1 + i*NB + j] <= WP'(prod_ext << ((i + j) * MUL_DIGIT));
			end
		end
	end

	for (genvar k = NPP; k < NLEAF; k++) begin : g_pad
		always_ff @(posedge clk) begin
			node_q[NLEAF-1 + k] <= '0;
		end
	end

	for (genvar n = 0; n < NLEAF - 1; n++) begin : g_sum
		always_ff @(posedge clk) begin
			node_q[n] <= node_q[2*n+1] + node_q[2*n+2];
		end
	end

	assign p = $signed(node_q[0]);

endmodule

`default_nettype wire

// ===== hdl/ldpp_delay.sv =====
// ldpp_delay: fixed-depth register delay line used to align operands
// with multiplier outputs. No dependencies.
`default_nettype none

module ldpp_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== hdl/ldpp_lane.sv =====
// ldpp_lane: full distortion pipeline for one point (radial polynomial in
// Horner form, tangential terms, round and saturate). Uses ldpp_pkg, ldpp_mul, ldpp_delay.
`default_nettype none

module ldpp_lane
	import ldpp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] u,
	input  logic signed [COORD_WIDTH-1:0] v,
	input  ldpp_coef_t                    coef,
	output logic                          res_valid,
	output ldpp_lane_t                    res
);

	localparam int W = COORD_WIDTH;
	localparam int F = FRAC_BITS;

	// exact widths of every intermediate
	localparam int R2W = 2 * W + 1;
	localparam int AW  = 2 * W + 2;
	localparam int H1W = W + R2W;
	localparam int G1W = imax(H1W, W + 2 * F) + 1;
	localparam int H2W = G1W + R2W;
	localparam int G2W = imax(H2W, W + 4 * F) + 1;
	localparam int H3W = G2W + R2W;
	localparam int SW  = imax(H3W, 7 * F + 2) + 1;
	localparam int XSW = W + SW;
	localparam int TPW = W + AW;
	localparam int TW  = TPW + 2;
	localparam int XW  = imax(imax(XSW, TW + 5 * F), 7 * F + 1) + 2;
	localparam int QW  = XW - 7 * F;

	localparam int L1  = mul_lat(W, W);
	localparam int LH1 = mul_lat(W, R2W);
	localparam int LT  = mul_lat(W, AW);
	localparam int LH2 = mul_lat(G1W, R2W);
	localparam int LH3 = mul_lat(G2W, R2W);
	localparam int LXS = mul_lat(W, SW);

	localparam int TB    = L1 + 1;
	localparam int TH    = TB + LH1 + LH2 + LH3 + 3;
	localparam int DLY_T = TH + LXS - (TB + LT + 1);
	localparam int LAT   = TH + LXS + 2;

	localparam logic [SW-1:0] ONE_S = SW'(1) << (7 * F);
	localparam logic [XW-1:0] HALF  = XW'(1) << (7 * F - 1);

	logic signed [W-1:0] k1, k2, k3, p1, p2;

	logic signed [W-1:0]     u_s0, v_s0;
	logic signed [2*W-1:0]   u2, v2, uv;
	logic signed [R2W-1:0]   r2_s1;
	logic signed [AW-1:0]    au_s1, av_s1, uv_s1;
	logic signed [H1W-1:0]   h1;
	logic signed [R2W-1:0]   r2_d1, r2_d2;
	logic signed [G1W-1:0]   g1_s2;
	logic signed [H2W-1:0]   h2;
	logic signed [G2W-1:0]   g2_s3;
	logic signed [H3W-1:0]   h3;
	logic signed [SW-1:0]    s_s4;
	logic signed [W-1:0]     u_d, v_d;
	logic signed [XSW-1:0]   xs, ys;
	logic signed [TPW-1:0]   ma, mb, mc, md;
	logic signed [TW-1:0]    tx_s2, ty_s2, tx_d, ty_d;
	logic signed [XW-1:0]    x_s5, y_s5;
	logic [W:0]              clip_x, clip_y;
	logic [LAT:0]            vld_q;

	assign k1 = coef.k1;
	assign k2 = coef.k2;
	assign k3 = coef.k3;
	assign p1 = coef.p1;
	assign p2 = coef.p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:0], in_valid};
		end
	end

	assign res_valid = vld_q[LAT];

	always_ff @(posedge clk) begin
		u_s0 <= u;
		v_s0 <= v;
	end

	// squares and cross term
	ldpp_mul #(.WA(W), .WB(W)) u_mul_uu (.clk(clk), .a(u_s0), .b(u_s0), .p(u2));
	ldpp_mul #(.WA(W), .WB(W)) u_mul_vv (.clk(clk), .a(v_s0), .b(v_s0), .p(v2));
	ldpp_mul #(.WA(W), .WB(W)) u_mul_uv (.clk(clk), .a(u_s0), .b(v_s0), .p(uv));

	// r2, and r2 + 2u^2 / r2 + 2v^2 for the tangential terms
	always_ff @(posedge clk) begin
		r2_s1 <= R2W'(u2) + R2W'(v2);
		au_s1 <= (AW'(u2) << 1) + AW'(u2) + AW'(v2);
		av_s1 <= (AW'(v2) << 1) + AW'(v2) + AW'(u2);
		uv_s1 <= AW'(uv);
	end

	// radial polynomial, Horner form: s = 2^7F + r2*(k1*2^4F + r2*(k2*2^2F + r2*k3))
	ldpp_mul #(.WA(W), .WB(R2W)) u_mul_h1 (.clk(clk), .a(k3), .b(r2_s1), .p(h1));

	ldpp_delay #(.WIDTH(R2W), .DEPTH(LH1 + 1)) u_dly_r1 (.clk(clk), .d(r2_s1), .q(r2_d1));

	always_ff @(posedge clk) begin
		g1_s2 <= G1W'(h1) + (G1W'(k2) << (2 * F));
	end

	ldpp_mul #(.WA(G1W), .WB(R2W)) u_mul_h2 (.clk(clk), .a(g1_s2), .b(r2_d1), .p(h2));

	ldpp_delay #(.WIDTH(R2W), .DEPTH(LH2 + 1)) u_dly_r2 (.clk(clk), .d(r2_d1), .q(r2_d2));

	always_ff @(posedge clk) begin
		g2_s3 <= G2W'(h2) + (G2W'(k1) << (4 * F));
	end

	ldpp_mul #(.WA(G2W), .WB(R2W)) u_mul_h3 (.clk(clk), .a(g2_s3), .b(r2_d2), .p(h3));

	always_ff @(posedge clk) begin
		s_s4 <= SW'(h3) + ONE_S;
	end

	ldpp_delay #(.WIDTH(W), .DEPTH(TH)) u_dly_u (.clk(clk), .d(u_s0), .q(u_d));
	ldpp_delay #(.WIDTH(W), .DEPTH(TH)) u_dly_v (.clk(clk), .d(v_s0), .q(v_d));

	ldpp_mul #(.WA(W), .WB(SW)) u_mul_xs (.clk(clk), .a(u_d), .b(s_s4), .p(xs));
	ldpp_mul #(.WA(W), .WB(SW)) u_mul_ys (.clk(clk), .a(v_d), .b(s_s4), .p(ys));

	// tangential terms, scale 2^-3F before the 5F shift
	ldpp_mul #(.WA(W), .WB(AW)) u_mul_ma (.clk(clk), .a(p1), .b(uv_s1), .p(ma));
	ldpp_mul #(.WA(W), .WB(AW)) u_mul_mb (.clk(clk), .a(p2), .b(au_s1), .p(mb));
	ldpp_mul #(.WA(W), .WB(AW)) u_mul_mc (.clk(clk), .a(p1), .b(av_s1), .p(mc));
	ldpp_mul #(.WA(W), .WB(AW)) u_mul_md (.clk(clk), .a(p2), .b(uv_s1), .p(md));

	always_ff @(posedge clk) begin
		tx_s2 <= (TW'(ma) << 1) + TW'(mb);
		ty_s2 <= TW'(mc) + (TW'(md) << 1);
	end

	ldpp_delay #(.WIDTH(TW), .DEPTH(DLY_T)) u_dly_tx (.clk(clk), .d(tx_s2), .q(tx_d));
	ldpp_delay #(.WIDTH(TW), .DEPTH(DLY_T)) u_dly_ty (.clk(clk), .d(ty_s2), .q(ty_d));

	// sum at scale 2^-8F, half an output LSB added for round to nearest
	always_ff @(posedge clk) begin
		x_s5 <= XW'(xs) + (XW'(tx_d) << (5 * F)) + HALF;
		y_s5 <= XW'(ys) + (XW'(ty_d) << (5 * F)) + HALF;
	end

	// MSB of the result flags a clip
	function automatic logic [W:0] clip(input logic [QW-1:0] q);
		logic [QW-W:0] hi;
		hi = q[QW-1:W-1];
		if ((&hi) || (~|hi)) begin
			clip = {1'b0, q[W-1:0]};
		end else if (q[QW-1]) begin
			clip = {1'b1, 1'b1, {(W-1){1'b0}}};
		end else begin
			clip = {1'b1, 1'b0, {(W-1){1'b1}}};
		end
	endfunction

	assign clip_x = clip(x_s5[XW-1:7*F]);
	assign clip_y = clip(y_s5[XW-1:7*F]);

	always_ff @(posedge clk) begin
		res.x   <= clip_x[W-1:0];
		res.y   <= clip_y[W-1:0];
		res.sat <= clip_x[W] | clip_y[W];
	end

endmodule

`default_nettype wire

// ===== hdl/ldpp_merge.sv =====
// ldpp_merge: combines the source and destination lane results into one
// result item and drives the result strobe. Uses ldpp_pkg.
`default_nettype none

module ldpp_merge
	import ldpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	input  ldpp_lane_t src,
	input  logic       dst_valid,
	input  ldpp_lane_t dst,
	output logic       done,
	output ldpp_out_t  result
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= src_valid & dst_valid;
		end
	end

	always_ff @(posedge clk) begin
		result.source_x_out <= src.x;
		result.source_y_out <= src.y;
		result.target_x_out <= dst.x;
		result.target_y_out <= dst.y;
		result.saturated    <= src.sat | dst.sat;
	end

endmodule

`default_nettype wire
